>>> rtl/bpg_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and arithmetic helpers for the bright pixel glow filter.
package bpg_pkg;

    localparam int DEFAULT_MAX_WIDTH = 1024;
    localparam int QUEUE_DEPTH       = 4;

    localparam int PIXEL_W        = 32;
    localparam int CHAN_W         = 8;
    localparam int SHARE_W        = 6;
    localparam int ACC_W          = 10;
    localparam int FRAME_WIDTH_W  = 11;
    localparam int FRAME_HEIGHT_W = 13;
    localparam int THRESHOLD_W    = 10;
    localparam int CFG_INDEX_W    = 2;
    localparam int CFG_DATA_W     = 13;

    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD    = 2'd2;

    localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RESET  = 11'd800;
    localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RESET = 13'd600;
    localparam logic [THRESHOLD_W-1:0]    THRESHOLD_RESET    = 10'd600;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

    // Per-item control decided by the front end and carried out by the back end.
    typedef struct packed {
        logic       mem_shift;  // read and rotate the line buffers
        logic       emit;       // this item produces a result
        logic       frame_end;  // the result closes the frame
        logic       col_ok;     // column lies inside the frame border
        logic [2:0] row_ok;     // per window row: row lies inside the frame border
    } bpg_ctrl_t;

    localparam int CTRL_W = $bits(bpg_ctrl_t);

    // floor(v * 15 / 100) = floor(3v / 20), computed as (3v * 205) >> 12,
    // which is exact over the whole 8-bit input range.
    function automatic logic [SHARE_W-1:0] glow_share(input logic [CHAN_W-1:0] v);
        logic [9:0]  triple;
        logic [17:0] scaled;
        triple = {2'b00, v} + {1'b0, v, 1'b0};
        scaled = 18'(triple) * 18'd205;
        return scaled[17:12];
    endfunction

endpackage

>>> rtl/bpg_queue.sv
`timescale 1ns / 1ps
// Small register queue that decouples the classifying front end from the window back end.
module bpg_queue #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = bpg_pkg::QUEUE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [DATA_W-1:0] in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] out_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] slot_reg [DEPTH];
    logic [PW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]     count_reg, count_next;
    logic              push, pop;

    assign in_ready  = (count_reg != NW'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + NW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - NW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_data;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg <= NW'(DEPTH)))
        else $error("queue fill count exceeds its depth");

endmodule

>>> rtl/bpg_front.sv
`timescale 1ns / 1ps
// Front end: configuration registers, raster position counters and item classification.
module bpg_front #(
    parameter int MAX_WIDTH = bpg_pkg::DEFAULT_MAX_WIDTH,
    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
    localparam int CW = $clog2(MAX_WIDTH + 1)
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [bpg_pkg::PIXEL_W-1:0]       s_tdata,
    input  logic                              s_tuser,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bpg_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [bpg_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic                              push_valid,
    input  logic                              push_ready,
    output bpg_pkg::bpg_ctrl_t                push_ctrl,
    output logic [AW-1:0]                     push_addr,
    output logic [bpg_pkg::PIXEL_W-1:0]       push_px,
    output logic [bpg_pkg::THRESHOLD_W-1:0]   threshold
);

    localparam int FW = bpg_pkg::FRAME_WIDTH_W;
    localparam int HW = bpg_pkg::FRAME_HEIGHT_W;
    localparam int TW = bpg_pkg::THRESHOLD_W;
    localparam int WW = (CW > FW) ? CW : FW;

    logic [FW-1:0] width_cfg_reg;
    logic [HW-1:0] height_cfg_reg;
    logic [TW-1:0] threshold_reg;

    logic [AW-1:0] col_reg, col_next;
    logic [HW-1:0] row_reg, row_next;
    logic [CW-1:0] drain_reg, drain_next;

    logic [WW-1:0] width_ext;
    logic [CW-1:0] eff_w;
    logic [HW-1:0] eff_h;
    logic [HW-1:0] h_m2;
    logic [CW-1:0] col_ext;
    logic [CW-1:0] pos;
    logic          pixel_phase;
    logic          last_col;
    logic          col_ok;
    logic [2:0]    row_ok;
    logic          keep;
    logic          accept;
    logic          geom_write;

    assign cfg_ready  = 1'b1;
    assign s_tready   = push_ready;
    assign threshold  = threshold_reg;
    assign accept     = s_tvalid && push_ready;
    assign push_valid = accept && keep;
    assign geom_write = cfg_valid &&
                        ((cfg_index == bpg_pkg::CFG_FRAME_WIDTH) ||
                         (cfg_index == bpg_pkg::CFG_FRAME_HEIGHT));

    // Effective geometry after clamping to the supported range.
    always_comb begin
        width_ext = WW'(width_cfg_reg);
        if (width_ext < WW'(3)) begin
            eff_w = CW'(3);
        end else if (width_ext > WW'(MAX_WIDTH)) begin
            eff_w = CW'(MAX_WIDTH);
        end else begin
            eff_w = CW'(width_ext);
        end
        eff_h = (height_cfg_reg < HW'(3)) ? HW'(3) : height_cfg_reg;
        h_m2  = eff_h - HW'(2);
    end

    always_comb begin
        pixel_phase = (row_reg < eff_h);
        col_ext     = CW'(col_reg);
        last_col    = ((col_ext + CW'(1)) >= eff_w);
        pos         = pixel_phase ? col_ext : drain_reg;
        col_ok      = (pos != '0) && (pos <= (eff_w - CW'(2)));
        // Window row j holds the pixel row (row_reg - (2 - j)); it must lie in 1..h-2.
        for (int j = 0; j < 3; j++) begin
            row_ok[j] = (row_reg >= HW'(3 - j)) && (row_reg <= (h_m2 + HW'(2 - j)));
        end
    end

    always_comb begin
        keep       = 1'b0;
        push_ctrl  = '0;
        push_addr  = '0;
        push_px    = '0;
        col_next   = col_reg;
        row_next   = row_reg;
        drain_next = drain_reg;
        if (pixel_phase) begin
            keep             = (s_tuser == bpg_pkg::OP_PIXEL);
            push_ctrl.mem_shift = 1'b1;
            push_ctrl.emit   = (col_reg == '0) ? (row_reg >= HW'(2)) : (row_reg >= HW'(1));
            push_ctrl.col_ok = col_ok;
            push_ctrl.row_ok = row_ok;
            push_addr        = col_reg;
            push_px          = s_tdata;
            if (last_col) begin
                col_next   = '0;
                row_next   = row_reg + HW'(1);
                drain_next = '0;
            end else begin
                col_next = col_reg + AW'(1);
            end
        end else if (drain_reg < eff_w) begin
            keep             = (s_tuser == bpg_pkg::OP_DRAIN);
            push_ctrl.mem_shift = 1'b1;
            push_ctrl.emit   = 1'b1;
            push_ctrl.col_ok = col_ok;
            push_ctrl.row_ok = row_ok;
            push_addr        = drain_reg[AW-1:0];
            drain_next       = drain_reg + CW'(1);
        end else begin
            // Closing drain item: the last pending pixel leaves and the frame restarts.
            keep                = (s_tuser == bpg_pkg::OP_DRAIN);
            push_ctrl.emit      = 1'b1;
            push_ctrl.frame_end = 1'b1;
            col_next            = '0;
            row_next            = '0;
            drain_next          = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_cfg_reg  <= bpg_pkg::FRAME_WIDTH_RESET;
            height_cfg_reg <= bpg_pkg::FRAME_HEIGHT_RESET;
            threshold_reg  <= bpg_pkg::THRESHOLD_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                bpg_pkg::CFG_FRAME_WIDTH:  width_cfg_reg  <= cfg_data[FW-1:0];
                bpg_pkg::CFG_FRAME_HEIGHT: height_cfg_reg <= cfg_data[HW-1:0];
                bpg_pkg::CFG_THRESHOLD:    threshold_reg  <= cfg_data[TW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg   <= '0;
            row_reg   <= '0;
            drain_reg <= '0;
        end else if (geom_write) begin
            col_reg   <= '0;
            row_reg   <= '0;
            drain_reg <= '0;
        end else if (accept && keep) begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            drain_reg <= drain_next;
        end
    end

    a_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (col_ext < eff_w))
        else $error("column counter left the frame width");

    a_row_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (row_reg <= eff_h))
        else $error("row counter passed the frame height");

    a_drain_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (drain_reg != '0) |-> (row_reg == eff_h))
        else $error("drain counter running outside the drain phase");

endmodule

>>> rtl/bpg_back.sv
`timescale 1ns / 1ps
// Back end: line buffers, 3x3 glow window and the saturating output stage.
module bpg_back #(
    parameter int MAX_WIDTH = bpg_pkg::DEFAULT_MAX_WIDTH,
    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [bpg_pkg::THRESHOLD_W-1:0]   threshold,
    input  logic                              q_valid,
    output logic                              q_ready,
    input  bpg_pkg::bpg_ctrl_t                q_ctrl,
    input  logic [AW-1:0]                     q_addr,
    input  logic [bpg_pkg::PIXEL_W-1:0]       q_px,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [bpg_pkg::PIXEL_W-1:0]       m_tdata,
    output logic                              m_tlast
);

    localparam int PXW = bpg_pkg::PIXEL_W;
    localparam int CHW = bpg_pkg::CHAN_W;
    localparam int SW  = bpg_pkg::SHARE_W;
    localparam int ACW = bpg_pkg::ACC_W;

    // Each entry holds the older row in the upper half and the newer row in the lower half.
    logic [2*PXW-1:0] line_mem [MAX_WIDTH];
    logic [2*PXW-1:0] rd_data_reg;

    logic               en;
    logic               s1_valid_reg;
    bpg_pkg::bpg_ctrl_t s1_ctrl_reg;
    logic [AW-1:0]      s1_addr_reg;
    logic [PXW-1:0]     s1_px_reg;

    logic [2:0][PXW-1:0]                col_px;
    logic [2:0][2:0][SW-1:0]            share_new;   // [row][chan]
    logic [2:0][ACW-1:0]                chan_sum;
    logic [2:0]                         src;

    logic [2:0][2:0][2:0][SW-1:0]       share_reg;   // [col][row][chan]
    logic [2:0][PXW-1:0]                center_reg;  // middle row pixel per column

    logic                s2_valid_reg;
    logic                s2_end_reg;
    logic [2:0][CHW-1:0] glow_chan;
    logic [ACW-1:0]      acc;

    logic                m_tvalid_reg;
    logic [PXW-1:0]      m_tdata_reg;
    logic                m_tlast_reg;

    // The whole back pipeline moves in lockstep whenever the output register can take data.
    assign en       = !m_tvalid_reg || m_tready;
    assign q_ready  = en;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            rd_data_reg <= line_mem[q_addr];
            if (s1_valid_reg && s1_ctrl_reg.mem_shift) begin
                line_mem[s1_addr_reg] <= {rd_data_reg[PXW-1:0], s1_px_reg};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= q_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_ctrl_reg <= q_ctrl;
            s1_addr_reg <= q_addr;
            s1_px_reg   <= q_px;
        end
    end

    // New window column: source test and glow share for each of its three pixels.
    always_comb begin
        col_px[0] = rd_data_reg[2*PXW-1:PXW];
        col_px[1] = rd_data_reg[PXW-1:0];
        col_px[2] = s1_px_reg;
        for (int j = 0; j < 3; j++) begin
            chan_sum[j] = ACW'(col_px[j][CHW-1:0]) + ACW'(col_px[j][2*CHW-1:CHW])
                        + ACW'(col_px[j][3*CHW-1:2*CHW]);
            src[j] = s1_ctrl_reg.row_ok[j] && s1_ctrl_reg.col_ok
                     && (chan_sum[j] > threshold);
            for (int k = 0; k < 3; k++) begin
                share_new[j][k] = src[j] ?
                    bpg_pkg::glow_share(col_px[j][k*CHW +: CHW]) : '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en && s1_valid_reg) begin
            share_reg[0]  <= share_reg[1];
            share_reg[1]  <= share_reg[2];
            share_reg[2]  <= share_new;
            center_reg[0] <= center_reg[1];
            center_reg[1] <= center_reg[2];
            center_reg[2] <= col_px[1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (en) begin
            s2_valid_reg <= s1_valid_reg && s1_ctrl_reg.emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_end_reg <= s1_ctrl_reg.frame_end;
        end
    end

    // Result pixel sits in the middle of the window; its eight neighbours add their shares.
    always_comb begin
        acc = '0;
        for (int k = 0; k < 3; k++) begin
            acc = ACW'(center_reg[1][k*CHW +: CHW]);
            for (int c = 0; c < 3; c++) begin
                for (int r = 0; r < 3; r++) begin
                    if (!(c == 1 && r == 1)) begin
                        acc = acc + ACW'(share_reg[c][r][k]);
                    end
                end
            end
            glow_chan[k] = (acc > ACW'(bpg_pkg::CHAN_MAX)) ? bpg_pkg::CHAN_MAX : acc[CHW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= {center_reg[1][4*CHW-1:3*CHW], glow_chan[2], glow_chan[1],
                            glow_chan[0]};
            m_tlast_reg <= s2_end_reg;
        end
    end

    a_window_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tready) |=> ($stable(share_reg) && $stable(center_reg)))
        else $error("glow window moved while the output was stalled");

endmodule

>>> rtl/bright_pixel_glow_filter_unit.sv
`timescale 1ns / 1ps
// Top level of the bright pixel glow filter: front end, decoupling queue and back end.
//
// Usage:
//   Pixels enter on the s_ channel in raster order, one transaction per pixel with
//   s_tuser low; tdata carries red, green, blue and alpha from the lowest byte up.
//   After the last pixel of a frame the source sends frame_width + 1 drain
//   transactions (s_tuser high). Transactions of the wrong kind for the current
//   position are taken and dropped without a result.
//   Results leave on the m_ channel frame_width + 1 positions behind their pixel;
//   m_tlast marks the last pixel of the frame, which the final drain produces.
//   The cfg channel writes frame_width (0), frame_height (1) and bright_threshold (2);
//   writing either geometry register restarts the frame. Write only while idle.
// Timing:
//   One transaction per clock is sustained while m_tready stays high; the
//   three-stage back end advances together and the line buffer memory serves one
//   read and one write per clock.
// Reset and stall:
//   aresetn clears the position counters and loads the register defaults; the line
//   buffers are not cleared and need no clearing pass. When m_tready is low the back
//   end holds, a four-entry queue absorbs the front end, and then s_tready drops.
module bright_pixel_glow_filter_unit #(
    parameter int MAX_WIDTH = bpg_pkg::DEFAULT_MAX_WIDTH
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [bpg_pkg::PIXEL_W-1:0]       s_tdata,   // red, green, blue, alpha
    input  logic                              s_tuser,   // opcode
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [bpg_pkg::PIXEL_W-1:0]       m_tdata,   // red, green, blue, alpha
    output logic                              m_tlast,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bpg_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [bpg_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int AW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int DATA_W = bpg_pkg::CTRL_W + AW + bpg_pkg::PIXEL_W;

    logic                              push_valid;
    logic                              push_ready;
    bpg_pkg::bpg_ctrl_t                push_ctrl;
    logic [AW-1:0]                     push_addr;
    logic [bpg_pkg::PIXEL_W-1:0]       push_px;
    logic [bpg_pkg::THRESHOLD_W-1:0]   threshold;

    logic                              q_valid;
    logic                              q_ready;
    logic [DATA_W-1:0]                 q_data;
    bpg_pkg::bpg_ctrl_t                q_ctrl;
    logic [AW-1:0]                     q_addr;
    logic [bpg_pkg::PIXEL_W-1:0]       q_px;

    assign {q_ctrl, q_addr, q_px} = q_data;

    bpg_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_ctrl  (push_ctrl),
        .push_addr  (push_addr),
        .push_px    (push_px),
        .threshold  (threshold)
    );

    bpg_queue #(
        .DATA_W (DATA_W),
        .DEPTH  (bpg_pkg::QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_data   ({push_ctrl, push_addr, push_px}),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_data)
    );

    bpg_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .threshold (threshold),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_ctrl    (q_ctrl),
        .q_addr    (q_addr),
        .q_px      (q_px),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the bright pixel glow filter: streams frames and compares glow.
module tb_top;

    localparam int PIXEL_W        = bpg_pkg::PIXEL_W;
    localparam int CHAN_W         = bpg_pkg::CHAN_W;
    localparam int FRAME_WIDTH_W  = bpg_pkg::FRAME_WIDTH_W;
    localparam int FRAME_HEIGHT_W = bpg_pkg::FRAME_HEIGHT_W;
    localparam int THRESHOLD_W    = bpg_pkg::THRESHOLD_W;
    localparam int CFG_INDEX_W    = bpg_pkg::CFG_INDEX_W;
    localparam int CFG_DATA_W     = bpg_pkg::CFG_DATA_W;

    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH  = bpg_pkg::CFG_FRAME_WIDTH;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT = bpg_pkg::CFG_FRAME_HEIGHT;
    localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD    = bpg_pkg::CFG_THRESHOLD;
    localparam logic                   OP_PIXEL         = bpg_pkg::OP_PIXEL;
    localparam logic                   OP_DRAIN         = bpg_pkg::OP_DRAIN;
    localparam logic [CHAN_W-1:0]      CHAN_MAX         = bpg_pkg::CHAN_MAX;

    localparam int                     LINE_MAX      = bpg_pkg::DEFAULT_MAX_WIDTH;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED    = 2'd3;
    localparam int                     SETTLE_CYCLES = 16;
    localparam int                     HOLD_CYCLES   = 300;
    localparam int                     PHASE_ITEMS   = 90;
    localparam int                     NOISE_PCT     = 5;

    localparam logic [PIXEL_W-1:0] DIRECTED_PX [9] = '{
        32'hFFFF_FFFF, 32'h0000_0000, 32'h7F01_80FE,
        32'h00FE_01FF, 32'h00FF_FFFF, 32'hFF00_0000,
        32'h8080_8080, 32'h01C8_C8C8, 32'hFFFF_FFFF
    };

    typedef struct {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
        logic              frame_end;
    } glow_pixel_t;

    // Tracks the raster position and the 3x3 window, and holds the glowed pixels still due.
    class glow_scoreboard;
        bit [PIXEL_W-1:0]        older_row [LINE_MAX];
        bit [PIXEL_W-1:0]        newer_row [LINE_MAX];
        bit [PIXEL_W-1:0]        win_px [3][3];
        bit                      win_src [3][3];
        int unsigned             col_pos;
        int unsigned             row_pos;
        int unsigned             drain_pos;
        bit [FRAME_WIDTH_W-1:0]  width_reg  = bpg_pkg::FRAME_WIDTH_RESET;
        bit [FRAME_HEIGHT_W-1:0] height_reg = bpg_pkg::FRAME_HEIGHT_RESET;
        bit [THRESHOLD_W-1:0]    thr_reg    = bpg_pkg::THRESHOLD_RESET;
        glow_pixel_t             expected_pixels [$];
        int                      errors;

        function int unsigned line_width();
            if (width_reg < 3) return 3;
            if (width_reg > LINE_MAX) return LINE_MAX;
            return width_reg;
        endfunction

        function int unsigned frame_rows();
            return (height_reg < 3) ? 3 : height_reg;
        endfunction

        function int pending_count();
            return expected_pixels.size();
        endfunction

        function void add_expected(glow_pixel_t px);
            expected_pixels.insert(expected_pixels.size(), px);
        endfunction

        // A pixel spreads glow only inside the frame border and when brighter than the threshold.
        function bit glow_source(bit [PIXEL_W-1:0] px, int unsigned r, int unsigned back,
                                 int unsigned c);
            int unsigned k;
            int unsigned sum;
            if (r < back) return 1'b0;
            k = r - back;
            if (k < 1 || k > frame_rows() - 2) return 1'b0;
            if (c < 1 || c > line_width() - 2) return 1'b0;
            sum = int'(px[7:0]) + int'(px[15:8]) + int'(px[23:16]);
            return sum > thr_reg;
        endfunction

        function void shift_column(int unsigned c, int unsigned r, bit [PIXEL_W-1:0] cur);
            bit [PIXEL_W-1:0] column [3];
            column[0] = older_row[c];
            column[1] = newer_row[c];
            column[2] = cur;
            for (int j = 0; j < 3; j++) begin
                win_px[j][0]  = win_px[j][1];
                win_px[j][1]  = win_px[j][2];
                win_px[j][2]  = column[j];
                win_src[j][0] = win_src[j][1];
                win_src[j][1] = win_src[j][2];
                win_src[j][2] = glow_source(column[j], r, 2 - j, c);
            end
            older_row[c] = newer_row[c];
            newer_row[c] = cur;
        endfunction

        // Glowed version of the middle-row pixel in window column cc.
        function glow_pixel_t glow_result(int cc, bit last);
            glow_pixel_t      res;
            bit [PIXEL_W-1:0] center;
            int unsigned      level [3];
            int unsigned      acc;
            center = win_px[1][cc];
            for (int k = 0; k < 3; k++) begin
                acc = center[8*k +: 8];
                for (int j = 0; j < 3; j++) begin
                    for (int q = cc - 1; q <= cc + 1; q++) begin
                        if (q < 0 || q > 2) continue;
                        if (j == 1 && q == cc) continue;
                        if (win_src[j][q]) acc += win_px[j][q][8*k +: 8] * 15 / 100;
                    end
                end
                level[k] = (acc > CHAN_MAX) ? CHAN_MAX : acc;
            end
            res.red       = 8'(level[0]);
            res.green     = 8'(level[1]);
            res.blue      = 8'(level[2]);
            res.alpha     = center[31:24];
            res.frame_end = last;
            return res;
        endfunction

        function void note_input(logic op, logic [PIXEL_W-1:0] px);
            int unsigned w;
            int unsigned h;
            int unsigned r;
            int unsigned c;
            int unsigned d;
            w = line_width();
            h = frame_rows();
            if (row_pos < h) begin
                r = row_pos;
                c = col_pos;
                if (op != OP_PIXEL) return;
                if (c == 0 && r >= 2) add_expected(glow_result(2, 1'b0));
                shift_column(c, r, px);
                if (c >= 1 && r >= 1) add_expected(glow_result(1, 1'b0));
                if (c + 1 >= w) begin
                    col_pos   = 0;
                    row_pos   = r + 1;
                    drain_pos = 0;
                end else begin
                    col_pos = c + 1;
                end
                return;
            end
            if (op != OP_DRAIN) return;
            if (drain_pos < w) begin
                d = drain_pos;
                if (d == 0) add_expected(glow_result(2, 1'b0));
                shift_column(d, h, '0);
                if (d >= 1) add_expected(glow_result(1, 1'b0));
                drain_pos = d + 1;
                return;
            end
            add_expected(glow_result(2, 1'b1));
            col_pos   = 0;
            row_pos   = 0;
            drain_pos = 0;
        endfunction

        function void write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_FRAME_WIDTH:  width_reg  = data[FRAME_WIDTH_W-1:0];
                CFG_FRAME_HEIGHT: height_reg = data[FRAME_HEIGHT_W-1:0];
                CFG_THRESHOLD: begin
                    thr_reg = data[THRESHOLD_W-1:0];
                    return;
                end
                default: return;
            endcase
            // Any geometry write restarts the frame.
            col_pos   = 0;
            row_pos   = 0;
            drain_pos = 0;
        endfunction

        function void check_result(logic [PIXEL_W-1:0] data, logic last);
            glow_pixel_t want;
            if (expected_pixels.size() == 0) begin
                $error("result with no pixel due: tdata %h tlast %b", data, last);
                errors++;
                return;
            end
            want = expected_pixels.pop_front();
            if (data[7:0] !== want.red) begin
                $error("red_out: expected %0d, got %0d", want.red, data[7:0]);
                errors++;
            end
            if (data[15:8] !== want.green) begin
                $error("green_out: expected %0d, got %0d", want.green, data[15:8]);
                errors++;
            end
            if (data[23:16] !== want.blue) begin
                $error("blue_out: expected %0d, got %0d", want.blue, data[23:16]);
                errors++;
            end
            if (data[31:24] !== want.alpha) begin
                $error("alpha_out: expected %0d, got %0d", want.alpha, data[31:24]);
                errors++;
            end
            if (last !== want.frame_end) begin
                $error("frame_end: expected %0d, got %0d", want.frame_end, last);
                errors++;
            end
        endfunction
    endclass

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [PIXEL_W-1:0]     s_tdata   = '0;
    logic                   s_tuser   = OP_PIXEL;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [PIXEL_W-1:0]     m_tdata;
    logic                   m_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_FRAME_WIDTH;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    glow_scoreboard sb;
    int             send_idle_pct;
    int             recv_stall_pct;
    bit             hold_off;
    int unsigned    frame_items;

    bright_pixel_glow_filter_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        if (hold_off) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
    end

    // Entered and left just after a falling edge; tvalid stays high between back-to-back items.
    task automatic push_item(input logic op, input logic [PIXEL_W-1:0] px);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= px;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        sb.note_input(op, px);
        @(negedge aclk);
    endtask

    // Waits until every due pixel has come out and the pipeline has gone quiet.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.pending_count() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        sb.write_register(idx, data);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // Bits above each register's width are random; the block must ignore them.
    task automatic configure(input logic [FRAME_WIDTH_W-1:0] w,
                             input logic [FRAME_HEIGHT_W-1:0] h,
                             input logic [THRESHOLD_W-1:0] t);
        settle();
        write_reg(CFG_FRAME_WIDTH, {2'($urandom_range(3)), w});
        write_reg(CFG_FRAME_HEIGHT, h);
        write_reg(CFG_THRESHOLD, {3'($urandom_range(7)), t});
    endtask

    function automatic logic [PIXEL_W-1:0] random_pixel();
        logic [PIXEL_W-1:0] px;
        px = $urandom;
        case ($urandom_range(9))
            0, 1, 2: px[23:0] = {8'($urandom_range(255, 190)), 8'($urandom_range(255, 190)),
                                 8'($urandom_range(255, 190))};
            3:       px[23:0] = '0;
            default: ;
        endcase
        return px;
    endfunction

    // Sends one frame and its drain. cut_at aborts the frame with a geometry write
    // before that pixel; retune_at rewrites the threshold before that pixel.
    task automatic send_frame(input int noise_pct, input int cut_at, input int retune_at);
        int unsigned w;
        int unsigned h;
        w = sb.line_width();
        h = sb.frame_rows();
        for (int i = 0; i < w * h; i++) begin
            if (i == retune_at) begin
                settle();
                write_reg(CFG_THRESHOLD, {3'($urandom_range(7)), 10'($urandom_range(1023))});
            end
            if (i == cut_at) begin
                settle();
                write_reg(CFG_FRAME_HEIGHT, 13'($urandom_range(6, 3)));
                return;
            end
            if ($urandom_range(99) < noise_pct) push_item(OP_DRAIN, $urandom);
            push_item(OP_PIXEL, random_pixel());
            frame_items++;
        end
        for (int i = 0; i <= w; i++) begin
            if ($urandom_range(99) < noise_pct) push_item(OP_PIXEL, $urandom);
            push_item(OP_DRAIN, $urandom);
            frame_items++;
        end
    endtask

    task automatic random_frame();
        logic [FRAME_WIDTH_W-1:0]  w;
        logic [FRAME_HEIGHT_W-1:0] h;
        logic [THRESHOLD_W-1:0]    t;
        int                        cut_at;
        int                        retune_at;
        int                        area;
        w = ($urandom_range(9) == 0) ? 11'($urandom_range(2)) : 11'($urandom_range(10, 3));
        h = ($urandom_range(9) == 0) ? 13'($urandom_range(2)) : 13'($urandom_range(7, 3));
        case ($urandom_range(9))
            0:       t = '0;
            1:       t = 10'd765;
            2:       t = 10'($urandom_range(1023, 766));
            default: t = 10'($urandom_range(700, 250));
        endcase
        configure(w, h, t);
        area      = sb.line_width() * sb.frame_rows();
        cut_at    = ($urandom_range(99) < 8) ? $urandom_range(area - 1) : -1;
        retune_at = ($urandom_range(99) < 10) ? $urandom_range(area - 1) : -1;
        send_frame(NOISE_PCT, cut_at, retune_at);
    endtask

    initial begin
        int unsigned target;
        sb = new;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Width and height below three both act as three; threshold zero lights the
        // center, which glows onto every border pixel, saturating the white corners.
        configure(11'd2, 13'd0, 10'd0);
        write_reg(CFG_UNUSED, 13'h1FFF);
        push_item(OP_DRAIN, 32'hFFFF_FFFF);
        foreach (DIRECTED_PX[i]) push_item(OP_PIXEL, DIRECTED_PX[i]);
        push_item(OP_PIXEL, 32'h0000_0000);
        repeat (4) push_item(OP_DRAIN, 32'h0000_0000);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 73; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 73; end
                default: begin send_idle_pct = 26; recv_stall_pct = 26; end
            endcase
            if (phase == 0) begin
                // Maximum width and a tall frame, cut short after a few pixels.
                configure(11'd1024, 13'd4096, 10'd400);
                send_frame(0, 40, -1);
                // Width above the maximum acts as the maximum; the frame is cut a little
                // way into its second row. The receiver holds off for a long stretch
                // meanwhile so the input side backs up.
                configure(11'd2047, 13'd3, 10'd500);
                fork
                    begin
                        @(posedge aclk) hold_off = 1'b1;
                        repeat (HOLD_CYCLES) @(posedge aclk);
                        hold_off = 1'b0;
                    end
                join_none
                send_frame(0, 1060, 600);
            end
            target = frame_items + PHASE_ITEMS;
            while (frame_items < target) random_frame();
        end

        settle();
        if (sb.errors == 0 && sb.pending_count() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
